/* sv/gbc_pkg.sv */
package gbc_pkg;

    // Cipher geometry.
    localparam int WORD_W      = 32;
    localparam int BLOCK_W     = 64;
    localparam int NUM_ROUNDS  = 32;
    localparam int NUM_KEYS    = 8;
    localparam int KEY_IDX_W   = 3;
    localparam int CFG_INDEX_W = 4;
    localparam int ROT_AMOUNT  = 11;
    localparam int NUM_SBOXES  = 8;

    // Rounds that take the key words in ascending order.
    localparam int ENC_FWD_ROUNDS = 24;
    localparam int DEC_FWD_ROUNDS = 8;

    // Request codes.
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // One block in flight between two round cells.
    typedef struct packed {
        logic  vld;
        logic  dec;
        word_t a;
        word_t b;
    } stage_t;

    // Substitution boxes; box 0 acts on the top nibble.
    localparam logic [3:0] SBOX [NUM_SBOXES][16] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7}
    };

    // Round function: key add, nibble substitution, rotate left.
    function automatic word_t round_fn(input word_t half, input word_t kw);
        word_t sum;
        word_t sub;
        sum = half + kw;
        for (int n = 0; n < NUM_SBOXES; n++) begin
            sub[WORD_W-1-4*n -: 4] = SBOX[n][sum[WORD_W-1-4*n -: 4]];
        end
        return (sub << ROT_AMOUNT) | (sub >> (WORD_W - ROT_AMOUNT));
    endfunction

endpackage

/* sv/gbc_round_cell.sv */
module gbc_round_cell #(
    parameter int ROUND = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gbc_pkg::stage_t stage_i,
    input  gbc_pkg::word_t  key_enc,
    input  gbc_pkg::word_t  key_dec,
    output gbc_pkg::stage_t stage_o
);
    import gbc_pkg::*;

    logic  vld_reg;
    logic  dec_reg;
    word_t a_reg;
    word_t b_reg;
    word_t a_next;
    word_t b_next;
    word_t key_sel;

    // Pick the key word for this round from the request direction.
    assign key_sel = (stage_i.dec == REQ_DECRYPT) ? key_dec : key_enc;

    // Even rounds update the second word, odd rounds the first.
    always_comb
    begin
        a_next = stage_i.a;
        b_next = stage_i.b;
        if ((ROUND % 2) == 0)
        begin
            b_next = stage_i.b ^ round_fn(stage_i.a, key_sel);
        end
        else
        begin
            a_next = stage_i.a ^ round_fn(stage_i.b, key_sel);
        end
    end

    // Valid flag follows the chain every cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= stage_i.vld;
        end
    end

    // Block halves and direction move on with the valid flag.
    always_ff @(posedge clk)
    begin
        dec_reg <= stage_i.dec;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign stage_o.vld = vld_reg;
    assign stage_o.dec = dec_reg;
    assign stage_o.a   = a_reg;
    assign stage_o.b   = b_reg;

endmodule

/* sv/gost_block_cipher.sv */
// GOST 28147-89 block cipher, fully unrolled into a chain of 32 round cells.
//
// Input: pulse start with req_type (0 encrypt, 1 decrypt) and block_in.
// The request is taken at a rising edge where start is high and busy is
// low; busy stays low, so one block may be started in every cycle.
// Output: done is high for exactly one cycle with block_out, once the
// block has passed all 32 round cells. Results leave in the order they
// came in. Each round cell holds one block and hands it to the next cell
// every cycle, so throughput is one block per cycle. The receiver cannot
// stall the block; results must be taken in the cycle they are shown.
// Keys: eight 32-bit words written over the cfg channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data); cfg_ready is always high and indexes
// beyond seven are dropped. Keys must only change while no block is in
// flight.
// Reset: clears every key word to zero and empties the chain; blocks in
// flight at reset are lost.
module gost_block_cipher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic [gbc_pkg::BLOCK_W-1:0]          block_in,
    output logic                                 done,
    output logic [gbc_pkg::BLOCK_W-1:0]          block_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [gbc_pkg::WORD_W-1:0]           cfg_data
);
    import gbc_pkg::*;

    word_t  key_reg [NUM_KEYS];
    stage_t stage [NUM_ROUNDS+1];
    logic   accept;

    // The chain never blocks new work.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Key register file; a transfer beyond the last key word is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_W'(NUM_KEYS)))
        begin
            key_reg[cfg_index[KEY_IDX_W-1:0]] <= cfg_data;
        end
    end

    // Head of the chain.
    assign stage[0].vld = accept;
    assign stage[0].dec = req_type;
    assign stage[0].a   = block_in[BLOCK_W-1:WORD_W];
    assign stage[0].b   = block_in[WORD_W-1:0];

    // One cell per round, keys wired by round position.
    for (genvar r = 0; r < NUM_ROUNDS; r++)
    begin : g_round
        localparam int KI     = r % NUM_KEYS;
        localparam int KI_ENC = (r < ENC_FWD_ROUNDS) ? KI : (NUM_KEYS - 1 - KI);
        localparam int KI_DEC = (r < DEC_FWD_ROUNDS) ? KI : (NUM_KEYS - 1 - KI);

        gbc_round_cell #(
            .ROUND (r)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .stage_i (stage[r]),
            .key_enc (key_reg[KI_ENC]),
            .key_dec (key_reg[KI_DEC]),
            .stage_o (stage[r+1])
        );
    end

    // Tail of the chain: halves swap on the way out.
    assign done      = stage[NUM_ROUNDS].vld;
    assign block_out = {stage[NUM_ROUNDS].b, stage[NUM_ROUNDS].a};

`ifndef SYNTHESIS
    // Every taken block comes out at the tail of the chain.
    a_latency_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##NUM_ROUNDS done)
        else $error("accepted block did not complete on time");

    // No result appears without a matching block taken at the head of the chain.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, NUM_ROUNDS))
        else $error("result without a matching request");

    // The direction flag travels unchanged through the middle of the chain.
    a_dec_carried: assert property (@(posedge clk) disable iff (!rst_n)
        stage[NUM_ROUNDS/2].vld |-> (stage[NUM_ROUNDS/2].dec ==
            $past(req_type, NUM_ROUNDS/2)))
        else $error("request direction lost in the chain");
`endif

endmodule
